// ----- sv/pts_pkg.sv -----
// shared types and constants for the power-of-two tile splitter
package pts_pkg;

   localparam int STACK_DEPTH_DEF = 32;
   localparam int MAX_TILES_DEF   = 64;
   localparam int MIN_TILE        = 128;
   localparam int MAX_DIM         = 1024;
   localparam int DIM_W           = 11;
   localparam int POS_W           = 10;
   localparam int CSR_INDEX_W     = 1;

   localparam logic [CSR_INDEX_W-1:0] CSR_MAX_TILE_WIDTH  = 1'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_MAX_TILE_HEIGHT = 1'd1;

   localparam logic [DIM_W-1:0] MAX_TILE_RESET = 11'd1024;

   typedef struct packed {
      logic [DIM_W-1:0] image_width;
      logic [DIM_W-1:0] image_height;
   } req_payload_type;

   typedef struct packed {
      logic [POS_W-1:0] tile_left;
      logic [POS_W-1:0] tile_top;
      logic [DIM_W-1:0] tile_width;
      logic [DIM_W-1:0] tile_height;
      logic             last_tile;
   } rsp_payload_type;

   typedef struct packed {
      logic [DIM_W-1:0] left;
      logic [DIM_W-1:0] top;
      logic [DIM_W-1:0] width;
      logic [DIM_W-1:0] height;
   } region_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_TILE,
      ST_PUSH,
      ST_POP,
      ST_LOAD
   } state_type;

   typedef enum logic [1:0] {
      PUSH_RIGHT,
      PUSH_BELOW,
      PUSH_CORNER
   } push_kind_type;

   typedef struct packed {
      logic          load_init;
      logic          load_pop;
      logic          emit;
      logic          last;
      push_kind_type push_kind;
   } cmd_type;

   typedef struct packed {
      logic out_free;
      logic req_empty;
      logic more_x;
      logic more_y;
   } status_type;

endpackage

// ----- sv/pts_ram.sv -----
// generic single write, single read ram with registered read data
module pts_ram #(
   parameter int WIDTH = 44,
   parameter int DEPTH = 32,
   localparam int ADDR_W = $clog2(DEPTH)
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- sv/pts_datapath.sv -----
// region register, tile size logic, config registers and result register
module pts_datapath (
   input  logic                                 clock,
   input  logic                                 reset,
   input  pts_pkg::req_payload_type             req_payload,
   input  logic                                 csr_wr_en,
   input  logic [pts_pkg::CSR_INDEX_W-1:0]      csr_index,
   input  logic [pts_pkg::DIM_W-1:0]            csr_wdata,
   input  pts_pkg::cmd_type                     cmd,
   output pts_pkg::status_type                  status,
   input  logic [$bits(pts_pkg::region_type)-1:0] ram_rd_data,
   output logic [$bits(pts_pkg::region_type)-1:0] ram_wr_data,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output pts_pkg::rsp_payload_type             rsp_payload
);

   import pts_pkg::*;

   function automatic logic [DIM_W-1:0] pick_side(input logic [DIM_W-1:0] size,
                                                  input logic [DIM_W-1:0] limit);
      logic [DIM_W:0]   t;
      logic [DIM_W:0]   hp;
      logic [DIM_W-1:0] m;
      logic [DIM_W-1:0] lim;
      m   = size - DIM_W'(1);
      t   = (DIM_W+1)'(1);
      for (int i = 0; i < DIM_W; i++) begin
         if (size != '0 && m[i]) t = (DIM_W+1)'(2) << i;
      end
      if (t > (DIM_W+1)'(MIN_TILE) && t != {1'b0, size}) t = t >> 1;
      lim = (limit == '0) ? DIM_W'(1) : limit;
      hp  = (DIM_W+1)'(1);
      for (int i = 0; i < DIM_W; i++) begin
         if (lim[i]) hp = (DIM_W+1)'(1) << i;
      end
      if (t > hp) t = hp;
      return t[DIM_W-1:0];
   endfunction

   logic [DIM_W-1:0] max_w_ff, max_w_in;
   logic [DIM_W-1:0] max_h_ff, max_h_in;
   region_type       cur_ff, cur_in;
   logic             rsp_valid_ff, rsp_valid_in;
   rsp_payload_type  rsp_payload_ff, rsp_payload_in;
   logic [DIM_W-1:0] tw, th;
   logic [DIM_W-1:0] init_w, init_h;
   region_type       push_region;

   always_comb begin
      tw     = pick_side(cur_ff.width, max_w_ff);
      th     = pick_side(cur_ff.height, max_h_ff);
      init_w = (req_payload.image_width > DIM_W'(MAX_DIM)) ? DIM_W'(MAX_DIM)
                                                           : req_payload.image_width;
      init_h = (req_payload.image_height > DIM_W'(MAX_DIM)) ? DIM_W'(MAX_DIM)
                                                            : req_payload.image_height;

      status.out_free  = !rsp_valid_ff || !rsp_stall;
      status.req_empty = (req_payload.image_width == '0) || (req_payload.image_height == '0);
      status.more_x    = cur_ff.width > tw;
      status.more_y    = cur_ff.height > th;

      case (cmd.push_kind)
         PUSH_RIGHT: begin
            push_region = '{cur_ff.left + tw, cur_ff.top, cur_ff.width - tw, th};
         end
         PUSH_BELOW: begin
            push_region = '{cur_ff.left, cur_ff.top + th, tw, cur_ff.height - th};
         end
         default: begin
            push_region = '{cur_ff.left + tw, cur_ff.top + th,
                            cur_ff.width - tw, cur_ff.height - th};
         end
      endcase
      ram_wr_data = push_region;

      cur_in = cur_ff;
      if (cmd.load_init) begin
         cur_in = '{DIM_W'(0), DIM_W'(0), init_w, init_h};
      end else if (cmd.load_pop) begin
         cur_in = ram_rd_data;
      end

      max_w_in = max_w_ff;
      max_h_in = max_h_ff;
      if (csr_wr_en) begin
         unique case (csr_index)
            CSR_MAX_TILE_WIDTH:  max_w_in = csr_wdata;
            CSR_MAX_TILE_HEIGHT: max_h_in = csr_wdata;
            default: ;
         endcase
      end

      rsp_valid_in   = rsp_valid_ff;
      rsp_payload_in = rsp_payload_ff;
      if (cmd.emit) begin
         rsp_valid_in   = 1'b1;
         rsp_payload_in = '{cur_ff.left[POS_W-1:0], cur_ff.top[POS_W-1:0], tw, th, cmd.last};
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         max_w_ff     <= MAX_TILE_RESET;
         max_h_ff     <= MAX_TILE_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         max_w_ff     <= max_w_in;
         max_h_ff     <= max_h_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      cur_ff         <= cur_in;
      rsp_payload_ff <= rsp_payload_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

endmodule

// ----- sv/pts_ctrl.sv -----
// controller: sequencing, stack pointer and tile count
module pts_ctrl #(
   parameter int STACK_DEPTH = pts_pkg::STACK_DEPTH_DEF,
   parameter int MAX_TILES   = pts_pkg::MAX_TILES_DEF,
   localparam int ADDR_W = $clog2(STACK_DEPTH)
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  pts_pkg::status_type status,
   output pts_pkg::cmd_type    cmd,
   output logic                ram_wr_en,
   output logic [ADDR_W-1:0]   ram_wr_addr,
   output logic                ram_rd_en,
   output logic [ADDR_W-1:0]   ram_rd_addr
);

   import pts_pkg::*;

   localparam int SP_W  = $clog2(STACK_DEPTH + 1);
   localparam int CNT_W = $clog2(MAX_TILES + 1);

   state_type        state_ff, state_in;
   logic [SP_W-1:0]  sp_ff, sp_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [2:0]       mask_ff, mask_in;
   logic [1:0]       push_cnt;
   logic [SP_W+1:0]  sp_sum;
   logic [SP_W-1:0]  sp_sat;
   logic [SP_W-1:0]  sp_dec;
   logic             last;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         sp_ff    <= '0;
         count_ff <= '0;
         mask_ff  <= '0;
      end else begin
         state_ff <= state_in;
         sp_ff    <= sp_in;
         count_ff <= count_in;
         mask_ff  <= mask_in;
      end
   end

   always_comb begin
      push_cnt = {1'b0, status.more_x} + {1'b0, status.more_y}
               + {1'b0, status.more_x && status.more_y};
      sp_sum   = (SP_W+2)'(sp_ff) + (SP_W+2)'(push_cnt);
      sp_sat   = (sp_sum > (SP_W+2)'(STACK_DEPTH)) ? SP_W'(STACK_DEPTH) : sp_sum[SP_W-1:0];
      last     = (sp_sat == '0) || (count_ff == CNT_W'(MAX_TILES - 1));
      sp_dec   = sp_ff - SP_W'(1);

      state_in = state_ff;
      sp_in    = sp_ff;
      count_in = count_ff;
      mask_in  = mask_ff;

      cmd.load_init = 1'b0;
      cmd.load_pop  = 1'b0;
      cmd.emit      = 1'b0;
      cmd.last      = last;
      cmd.push_kind = PUSH_CORNER;
      ram_wr_en     = 1'b0;
      ram_rd_en     = 1'b0;
      ram_wr_addr   = sp_ff[ADDR_W-1:0];
      ram_rd_addr   = sp_dec[ADDR_W-1:0];
      req_stall     = (state_ff != ST_IDLE);

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid && !status.req_empty) begin
               cmd.load_init = 1'b1;
               sp_in         = '0;
               count_in      = '0;
               state_in      = ST_TILE;
            end
         end
         ST_TILE: begin
            if (status.out_free) begin
               cmd.emit = 1'b1;
               count_in = count_ff + CNT_W'(1);
               if (last) begin
                  state_in = ST_IDLE;
               end else if (push_cnt != '0) begin
                  mask_in  = {status.more_x && status.more_y, status.more_y, status.more_x};
                  state_in = ST_PUSH;
               end else begin
                  state_in = ST_POP;
               end
            end
         end
         ST_PUSH: begin
            if (mask_ff[0]) begin
               cmd.push_kind = PUSH_RIGHT;
               mask_in[0]    = 1'b0;
            end else if (mask_ff[1]) begin
               cmd.push_kind = PUSH_BELOW;
               mask_in[1]    = 1'b0;
            end else begin
               cmd.push_kind = PUSH_CORNER;
               mask_in[2]    = 1'b0;
            end
            // full stack drops the region
            ram_wr_en = (sp_ff < SP_W'(STACK_DEPTH));
            if (ram_wr_en) sp_in = sp_ff + SP_W'(1);
            if (mask_in == '0) state_in = ST_POP;
         end
         ST_POP: begin
            ram_rd_en = 1'b1;
            sp_in     = sp_dec;
            state_in  = ST_LOAD;
         end
         ST_LOAD: begin
            cmd.load_pop = 1'b1;
            state_in     = ST_TILE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   a_pop_nonempty: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_POP |-> sp_ff != '0)
      else $error("pop from empty stack");

   a_sp_bound: assert property (@(posedge clock) disable iff (reset)
      sp_ff <= SP_W'(STACK_DEPTH))
      else $error("stack pointer beyond depth");

   a_emit_free: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |-> status.out_free)
      else $error("tile emitted into a full result register");

   a_last_idle: assert property (@(posedge clock) disable iff (reset)
      cmd.emit && cmd.last |=> state_ff == ST_IDLE)
      else $error("work continues after last tile");

endmodule

// ----- sv/pow2_tile_splitter_top.sv -----
// top level of the power-of-two tile splitter
// first tile: the request loads the region register, then the tile enters the result register once it is free
// each further tile steps through emit (waiting while the result register is full), one stack push
// per new region (0 to 3), then a stack read and a load through the registered ram read port
// up to MAX_TILES tiles per image; req_stall stays high until the last tile is registered
// reset clears control state and the config registers; the stack ram is not cleared
module pow2_tile_splitter_top #(
   parameter int STACK_DEPTH = pts_pkg::STACK_DEPTH_DEF,
   parameter int MAX_TILES   = pts_pkg::MAX_TILES_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  pts_pkg::req_payload_type        req_payload,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output pts_pkg::rsp_payload_type        rsp_payload,
   input  logic                            csr_wr_en,
   input  logic [pts_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [pts_pkg::DIM_W-1:0]       csr_wdata
);

   import pts_pkg::*;

   localparam int ADDR_W   = $clog2(STACK_DEPTH);
   localparam int REGION_W = $bits(region_type);

   cmd_type             cmd;
   status_type          status;
   logic                ram_wr_en;
   logic [ADDR_W-1:0]   ram_wr_addr;
   logic                ram_rd_en;
   logic [ADDR_W-1:0]   ram_rd_addr;
   logic [REGION_W-1:0] ram_wr_data;
   logic [REGION_W-1:0] ram_rd_data;

   pts_ctrl #(
      .STACK_DEPTH (STACK_DEPTH),
      .MAX_TILES   (MAX_TILES)
   ) u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .status      (status),
      .cmd         (cmd),
      .ram_wr_en   (ram_wr_en),
      .ram_wr_addr (ram_wr_addr),
      .ram_rd_en   (ram_rd_en),
      .ram_rd_addr (ram_rd_addr)
   );

   pts_datapath u_datapath (
      .clock       (clock),
      .reset       (reset),
      .req_payload (req_payload),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata),
      .cmd         (cmd),
      .status      (status),
      .ram_rd_data (ram_rd_data),
      .ram_wr_data (ram_wr_data),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload)
   );

   pts_ram #(
      .WIDTH (REGION_W),
      .DEPTH (STACK_DEPTH)
   ) u_stack (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

endmodule

// ----- tb/tb_pow2_tile_splitter_top.sv -----
// testbench for the power-of-two tile splitter: directed and random images checked per tile
`timescale 1ns / 1ps

module tb_pow2_tile_splitter_top;
   import pts_pkg::*;

   localparam int LIMIT_CYCLES  = 1000000;
   localparam int SETTLE_CYCLES = 16;
   localparam int IDLE_PCT      = 26;
   localparam int MAX_REPORTS   = 100;

   logic                   clock;
   logic                   reset;
   logic                   req_valid;
   logic                   req_stall;
   req_payload_type        req_payload;
   logic                   rsp_valid;
   logic                   rsp_stall;
   rsp_payload_type        rsp_payload;
   logic                   csr_wr_en;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [DIM_W-1:0]       csr_wdata;

   rsp_payload_type tiles_due [$];
   region_type      region_stack [STACK_DEPTH_DEF];
   int              region_count;
   int unsigned     limit_w;
   int unsigned     limit_h;
   bit              calm;
   int              errors;
   int              cycles;
   int              images_sent;
   int              empty_images;
   int              capped_images;
   int              tiles_checked;
   int              csr_writes;

   pow2_tile_splitter_top dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles > LIMIT_CYCLES) begin
         $display("timeout at %0t with %0d tiles outstanding", $time, tiles_due.size());
         $display("tb_pow2_tile_splitter_top: errors");
         $finish;
      end
   end

   always @(negedge clock) begin
      rsp_stall <= calm ? 1'b0 : ($urandom_range(99) < IDLE_PCT);
   end

   always @(posedge clock) begin : check_tile
      rsp_payload_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (tiles_due.size() == 0) begin
            errors++;
            if (errors <= MAX_REPORTS)
               $display("%0t: unexpected tile left %0d top %0d w %0d h %0d last %0b",
                        $time, rsp_payload.tile_left, rsp_payload.tile_top,
                        rsp_payload.tile_width, rsp_payload.tile_height,
                        rsp_payload.last_tile);
         end else begin
            want = tiles_due.pop_front();
            tiles_checked++;
            if (rsp_payload.tile_left !== want.tile_left ||
                rsp_payload.tile_top !== want.tile_top ||
                rsp_payload.tile_width !== want.tile_width ||
                rsp_payload.tile_height !== want.tile_height ||
                rsp_payload.last_tile !== want.last_tile) begin
               errors++;
               if (errors <= MAX_REPORTS)
                  $display("%0t: expected %0d,%0d %0dx%0d last %0b actual %0d,%0d %0dx%0d last %0b",
                           $time, want.tile_left, want.tile_top, want.tile_width,
                           want.tile_height, want.last_tile, rsp_payload.tile_left,
                           rsp_payload.tile_top, rsp_payload.tile_width,
                           rsp_payload.tile_height, rsp_payload.last_tile);
            end
         end
      end
   end

   function automatic int unsigned pow2_side(int unsigned size, int unsigned limit);
      int unsigned t;
      t = 1;
      while (t < size)
         t = t << 1;
      if (t > MIN_TILE && t != size)
         t = t >> 1;
      if (limit == 0)
         limit = 1;
      while (t > limit)
         t = t >> 1;
      return t;
   endfunction

   function automatic void stack_region(int unsigned l, int unsigned t, int unsigned wd,
                                        int unsigned ht);
      region_type r;
      if (region_count < STACK_DEPTH_DEF) begin
         r.left   = l[DIM_W-1:0];
         r.top    = t[DIM_W-1:0];
         r.width  = wd[DIM_W-1:0];
         r.height = ht[DIM_W-1:0];
         region_stack[region_count] = r;
         region_count++;
      end
   endfunction

   function automatic void split_image(logic [DIM_W-1:0] w_in, logic [DIM_W-1:0] h_in);
      int unsigned     w;
      int unsigned     h;
      int unsigned     tw;
      int unsigned     th;
      region_type      r;
      rsp_payload_type tile;
      rsp_payload_type batch [$];
      logic            more_x;
      logic            more_y;
      w = (w_in > MAX_DIM) ? MAX_DIM : 32'(w_in);
      h = (h_in > MAX_DIM) ? MAX_DIM : 32'(h_in);
      if (w == 0 || h == 0) begin
         empty_images++;
      end else begin
         region_count = 0;
         stack_region(0, 0, w, h);
         while (region_count > 0 && batch.size() < MAX_TILES_DEF) begin
            region_count--;
            r  = region_stack[region_count];
            tw = pow2_side(32'(r.width), limit_w);
            th = pow2_side(32'(r.height), limit_h);
            tile.tile_left   = r.left[POS_W-1:0];
            tile.tile_top    = r.top[POS_W-1:0];
            tile.tile_width  = tw[DIM_W-1:0];
            tile.tile_height = th[DIM_W-1:0];
            tile.last_tile   = 1'b0;
            batch = {batch, tile};
            more_x = 32'(r.width) > tw;
            more_y = 32'(r.height) > th;
            if (more_x)
               stack_region(32'(r.left) + tw, 32'(r.top), 32'(r.width) - tw, th);
            if (more_y)
               stack_region(32'(r.left), 32'(r.top) + th, tw, 32'(r.height) - th);
            if (more_x && more_y)
               stack_region(32'(r.left) + tw, 32'(r.top) + th, 32'(r.width) - tw,
                            32'(r.height) - th);
         end
         batch[batch.size()-1].last_tile = 1'b1;
         if (batch.size() == MAX_TILES_DEF)
            capped_images++;
         foreach (batch[i])
            tiles_due = {tiles_due, batch[i]};
      end
   endfunction

   task automatic send_image(input logic [DIM_W-1:0] w, input logic [DIM_W-1:0] h);
      req_payload_type item;
      item.image_width  = w;
      item.image_height = h;
      while (!calm && $urandom_range(99) < IDLE_PCT) begin
         @(negedge clock);
         req_valid <= 1'b0;
      end
      @(negedge clock);
      req_valid   <= 1'b1;
      req_payload <= item;
      @(posedge clock);
      while (req_stall)
         @(posedge clock);
      split_image(w, h);
      images_sent++;
   endtask

   task automatic settle();
      @(negedge clock);
      req_valid <= 1'b0;
      while (tiles_due.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_limit(input logic [CSR_INDEX_W-1:0] idx, input logic [DIM_W-1:0] value);
      @(negedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(negedge clock);
      csr_wr_en <= 1'b0;
      if (idx == CSR_MAX_TILE_WIDTH)
         limit_w = 32'(value);
      else
         limit_h = 32'(value);
      csr_writes++;
   endtask

   task automatic set_limits(input logic [DIM_W-1:0] wl, input logic [DIM_W-1:0] hl);
      settle();
      write_limit(CSR_MAX_TILE_WIDTH, wl);
      write_limit(CSR_MAX_TILE_HEIGHT, hl);
   endtask

   function automatic logic [DIM_W-1:0] rand_dim();
      logic [DIM_W-1:0] d;
      case ($urandom_range(9))
         0:       d = DIM_W'($urandom_range(2047));
         1:       d = DIM_W'($urandom_range(16, 1));
         2, 3:    d = DIM_W'((32'd1 << $urandom_range(10)) + $urandom_range(2) - 1);
         default: d = DIM_W'($urandom_range(1024, 1));
      endcase
      return d;
   endfunction

   function automatic logic [DIM_W-1:0] rand_limit();
      logic [DIM_W-1:0] l;
      case ($urandom_range(7))
         0:       l = 11'd128;
         1:       l = 11'd1024;
         2:       l = DIM_W'($urandom_range(2047));
         3:       l = DIM_W'(32'd1 << $urandom_range(10));
         default: l = DIM_W'($urandom_range(1024, 128));
      endcase
      return l;
   endfunction

   task automatic test_default_limits();
      send_image(11'd1, 11'd1);
      send_image(11'd1024, 11'd1024);
      send_image(11'd2047, 11'd2047);
      send_image(11'd1025, 11'd2000);
      send_image(11'd0, 11'd7);
      send_image(11'd9, 11'd0);
      send_image(11'd0, 11'd0);
      send_image(11'd128, 11'd128);
      send_image(11'd129, 11'd129);
      send_image(11'd100, 11'd100);
      send_image(11'd1000, 11'd600);
      send_image(11'd3, 11'd1024);
      send_image(11'd1024, 11'd3);
      send_image(11'd256, 11'd255);
      send_image(11'd127, 11'd1023);
   endtask

   // zero limit behaves as one: tile cap and stack overflow
   task automatic test_unit_limits();
      set_limits(11'd0, 11'd0);
      send_image(11'd1024, 11'd1024);
      send_image(11'd5, 11'd3);
      set_limits(11'd1, 11'd2047);
      send_image(11'd700, 11'd1024);
   endtask

   task automatic test_limit_extremes();
      set_limits(11'd2047, 11'd128);
      send_image(11'd1024, 11'd1024);
      send_image(11'd700, 11'd300);
      set_limits(11'd128, 11'd1024);
      send_image(11'd1024, 11'd1024);
      send_image(11'd300, 11'd900);
   endtask

   task automatic test_random_mix();
      for (int phase = 0; phase < 9; phase++) begin
         settle();
         calm = (phase == 4);
         if (phase % 3 == 2)
            write_limit(CSR_INDEX_W'($urandom_range(1)), rand_limit());
         else
            set_limits(rand_limit(), rand_limit());
         for (int k = 0; k < 28; k++)
            send_image(rand_dim(), rand_dim());
      end
      calm = 1'b0;
   endtask

   initial begin
      reset       = 1'b1;
      req_valid   = 1'b0;
      req_payload = '0;
      rsp_stall   = 1'b0;
      csr_wr_en   = 1'b0;
      csr_index   = CSR_MAX_TILE_WIDTH;
      csr_wdata   = '0;
      calm        = 1'b0;
      limit_w     = 32'(MAX_TILE_RESET);
      limit_h     = 32'(MAX_TILE_RESET);
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_default_limits();
      test_unit_limits();
      test_limit_extremes();
      test_random_mix();
      settle();
      repeat (2 * SETTLE_CYCLES) @(posedge clock);

      $display("covered %0d images (%0d empty, %0d at the tile cap) and %0d limit writes",
               images_sent, empty_images, capped_images, csr_writes);
      $display("checked %0d tiles over %0d cycles", tiles_checked, cycles);
      if (errors == 0)
         $display("tb_pow2_tile_splitter_top: clean");
      else
         $display("tb_pow2_tile_splitter_top: errors");
      $finish;
   end

endmodule

// ----- pow2_tile_splitter_top.f -----
sv/pts_pkg.sv
sv/pts_ram.sv
sv/pts_datapath.sv
sv/pts_ctrl.sv
sv/pow2_tile_splitter_top.sv
tb/tb_pow2_tile_splitter_top.sv
